FILE: sv/bbe_pkg.sv
// Shared constants, command/status types and the binomial helper for the Bernstein evaluator.
package bbe_pkg;

  localparam int MAX_DEGREE_DEF = 15;
  localparam int DEG_LIMIT      = 31;
  localparam int FRAC_BITS      = 16;
  localparam int VAL_W          = 17;
  localparam int IDX_W          = 4;
  localparam logic [VAL_W-1:0] ONE_Q = VAL_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic load;
    logic qstep;
    logic term;
    logic scale;
    logic stepu;
  } bbe_cmd_t;

  typedef struct packed {
    logic q_done;
    logic k_last;
    logic out_free;
  } bbe_status_t;

  // Pascal triangle entry C(n,k), evaluated at elaboration.
  function automatic longint unsigned binom(int n, int k);
    longint unsigned row [DEG_LIMIT+1];
    int r;
    int c;
    for (c = 0; c <= DEG_LIMIT; c++) row[c] = 0;
    row[0] = 1;
    for (r = 1; r <= n; r++) begin
      row[r] = 1;
      for (c = r - 1; c >= 1; c--) row[c] = row[c] + row[c-1];
    end
    return row[k];
  endfunction

endpackage

FILE: sv/bbe_in_if.sv
// Input channel: degree and curve parameter.
interface bbe_in_if import bbe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] degree;
  logic [VAL_W-1:0] param_u;

  modport source (output valid, degree, param_u, input ready);
  modport sink   (input valid, degree, param_u, output ready);
endinterface

FILE: sv/bbe_out_if.sv
// Result channel: one basis value per transaction.
interface bbe_out_if import bbe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] basis_index;
  logic [VAL_W-1:0] basis_value;
  logic             last_term;

  modport source (output valid, basis_index, basis_value, last_term, input ready);
  modport sink   (input valid, basis_index, basis_value, last_term, output ready);
endinterface

FILE: sv/bernstein_basis_eval.sv
// Top level of the Bernstein basis evaluator: sequencer plus datapath.
//
//   channel     dir  handshake      payload
//   item_in     in   valid/ready    degree[3:0], param_u[16:0]
//   result_out  out  valid/ready    basis_index[3:0], basis_value[16:0], last_term
//
// An item of degree n is handled in this order: the accepting idle state, the build
// of the powers of (1-u), then per term a term product, a coefficient scale and a
// u power step, which the last term skips, all on one shared multiplier.
// rst is synchronous and active high; it clears the sequencer and the output valid.
// A stalled result_out holds the sequencer in its scale step; item_in is taken
// only when the previous item has issued its last result.
module bernstein_basis_eval import bbe_pkg::*; #(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bbe_in_if.sink    item_in,
  bbe_out_if.source result_out
);

  bbe_cmd_t    cmd;
  bbe_status_t status;

  bbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bbe_datapath #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .degree      (item_in.degree),
    .param_u     (item_in.param_u),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .basis_index (result_out.basis_index),
    .basis_value (result_out.basis_value),
    .last_term   (result_out.last_term)
  );

endmodule

FILE: sv/bbe_ctrl.sv
// Sequencer that steps the shared multiplier through power, term and scale operations.
module bbe_ctrl import bbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  bbe_status_t status,
  output bbe_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_QPOW  = 5'b00010,
    S_TERM  = 5'b00100,
    S_SCALE = 5'b01000,
    S_STEPU = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_QPOW;
        end
      end
      S_QPOW: begin
        // build (1-u)^j for j = 1..n
        if (status.q_done) begin
          state_next = S_TERM;
        end else begin
          cmd.qstep = 1'b1;
        end
      end
      S_TERM: begin
        cmd.term   = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.scale  = 1'b1;
          state_next = status.k_last ? S_IDLE : S_STEPU;
        end
      end
      S_STEPU: begin
        cmd.stepu  = 1'b1;
        state_next = S_TERM;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/bbe_datapath.sv
// Operand registers, power table, coefficient table, shared multiplier and output register.
module bbe_datapath import bbe_pkg::*; #(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  bbe_cmd_t         cmd,
  output bbe_status_t      status,
  input  logic [IDX_W-1:0] degree,
  input  logic [VAL_W-1:0] param_u,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] basis_index,
  output logic [VAL_W-1:0] basis_value,
  output logic             last_term
);

  localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
  localparam int COEF_W = MAX_DEGREE + 1;
  localparam int MA_W   = (COEF_W > VAL_W) ? COEF_W : VAL_W;
  localparam int PROD_W = MA_W + VAL_W;

  logic [COEF_W-1:0] coef_rom [MAX_DEGREE+1][MAX_DEGREE+1];

  for (genvar gi = 0; gi <= MAX_DEGREE; gi++) begin : g_row
    for (genvar gk = 0; gk <= MAX_DEGREE; gk++) begin : g_col
      assign coef_rom[gi][gk] = COEF_W'(binom(gi, gk));
    end
  end

  logic [DEG_W-1:0] n_r;
  logic [DEG_W-1:0] k_r;
  logic [DEG_W-1:0] j_r;
  logic [VAL_W-1:0] u_r;
  logic [VAL_W-1:0] w_r;
  logic [VAL_W-1:0] p_r;
  logic [VAL_W-1:0] q_cur;
  logic [VAL_W-1:0] t_r;
  logic [VAL_W-1:0] q_mem [MAX_DEGREE+1];

  logic [DEG_W-1:0]  n_in;
  logic [VAL_W-1:0]  u_in;
  logic [DEG_W-1:0]  j_inc;
  logic [DEG_W-1:0]  q_idx;
  logic [MA_W-1:0]   mul_a;
  logic [VAL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  prod_q;

  always_comb begin
    if (32'(degree) > MAX_DEGREE) begin
      n_in = DEG_W'(MAX_DEGREE);
    end else begin
      n_in = DEG_W'(degree);
    end
    u_in  = (param_u > ONE_Q) ? ONE_Q : param_u;
    j_inc = j_r + DEG_W'(1);
    q_idx = n_r - k_r;
  end

  // one shared multiplier, operands picked by the current command
  always_comb begin
    mul_a = MA_W'(p_r);
    mul_b = u_r;
    if (cmd.qstep) begin
      mul_a = MA_W'(q_cur);
      mul_b = w_r;
    end else if (cmd.term) begin
      mul_a = MA_W'(p_r);
      mul_b = q_mem[q_idx];
    end else if (cmd.scale) begin
      mul_a = MA_W'(coef_rom[n_r][k_r]);
      mul_b = t_r;
    end
    prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
    prod_q = VAL_W'(prod >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r      <= n_in;
      u_r      <= u_in;
      w_r      <= ONE_Q - u_in;
      p_r      <= ONE_Q;
      q_cur    <= ONE_Q;
      q_mem[0] <= ONE_Q;
      k_r      <= '0;
      j_r      <= '0;
    end
    if (cmd.qstep) begin
      q_cur        <= prod_q;
      q_mem[j_inc] <= prod_q;
      j_r          <= j_inc;
    end
    if (cmd.term) begin
      t_r <= prod_q;
    end
    if (cmd.stepu) begin
      p_r <= prod_q;
      k_r <= k_r + DEG_W'(1);
    end
    if (cmd.scale) begin
      basis_index <= IDX_W'(k_r);
      basis_value <= VAL_W'(prod);
      last_term   <= (k_r == n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.scale) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.q_done   = (j_r == n_r);
  assign status.k_last   = (k_r == n_r);
  assign status.out_free = !out_valid || out_ready;

endmodule

FILE: sv/bbe_checker.sv
// Port-level checks for the Bernstein evaluator, bound to the top level.
module bbe_checker import bbe_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] basis_value,
  input logic             last_term
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

  // no new item while a run still has results to give
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_term |-> !in_ready)
    else $error("input ready in the middle of a run");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> basis_value <= ONE_Q)
    else $error("basis value above one");

endmodule

bind bernstein_basis_eval bbe_checker u_bbe_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item_in.valid),
  .in_ready    (item_in.ready),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .basis_value (result_out.basis_value),
  .last_term   (result_out.last_term)
);
